>>> sv/tlvd_pkg.sv
package tlvd_pkg;

	localparam int unsigned LENGTH_BYTES = 2;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd64;
	localparam logic [7:0]  CMD_RESET = 8'hFF;
	localparam logic [7:0]  PAD_BYTE = 8'h00;

	typedef enum logic [2:0] {
		PH_CMD = 3'b001,
		PH_LEN = 3'b010,
		PH_PAY = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0]  command_code;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic        has_data;
		logic        last;
		logic        overflow;
	} res_t;

endpackage

>>> sv/tlvd_in_stage.sv
module tlvd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       fire,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import tlvd_pkg::*;

	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

>>> sv/tlvd_parser.sv
module tlvd_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	input  logic           fire,
	input  logic [7:0]     byte_s1,
	output logic           res_valid,
	output tlvd_pkg::res_t res
);
	import tlvd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [1:0]  seen_q, seen_d;
	logic [15:0] flen_q, flen_d;
	logic [15:0] count_q, count_d;
	logic [15:0] max_q;
	logic [15:0] count_inc;
	logic [15:0] flen_new;

	assign count_inc = count_q + 16'd1;
	assign flen_new = seen_q[0] ? (flen_q | {byte_s1, 8'h00}) : (flen_q | {8'h00, byte_s1});

	always_comb begin
		phase_d = phase_q;
		cmd_d = cmd_q;
		seen_d = seen_q;
		flen_d = flen_q;
		count_d = count_q;
		res_valid = 1'b0;
		res = '0;
		res.command_code = cmd_q;
		unique case (phase_q)
			PH_LEN: begin
				flen_d = flen_new;
				seen_d = seen_q + 2'd1;
				if ({1'b0, seen_d} >= 3'(LENGTH_BYTES)) begin
					if (flen_new == 16'd0) begin
						res_valid = 1'b1;
						res.last = 1'b1;
						phase_d = PH_CMD;
					end else begin
						count_d = 16'd0;
						phase_d = PH_PAY;
					end
				end
			end
			PH_PAY: begin
				count_d = count_inc;
				res_valid = 1'b1;
				res.payload_byte = byte_s1;
				res.payload_index = count_q;
				res.has_data = 1'b1;
				res.overflow = (count_q >= max_q);
				res.last = (count_inc == flen_q);
				if (res.last) begin
					phase_d = PH_CMD;
				end
			end
			default: begin
				if (byte_s1 != PAD_BYTE) begin
					cmd_d = byte_s1;
					seen_d = 2'd0;
					flen_d = 16'd0;
					phase_d = PH_LEN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			cmd_q <= CMD_RESET;
			seen_q <= 2'd0;
			flen_q <= 16'd0;
			count_q <= 16'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			cmd_q <= cmd_d;
			seen_q <= seen_d;
			flen_q <= flen_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register not one-hot");

	a_pay_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAY) |-> (flen_q != 16'd0))
		else $error("payload phase with zero length");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid && res.last) |=> (phase_q == PH_CMD))
		else $error("last result did not end the command");

endmodule

>>> sv/tlvd_out_stage.sv
module tlvd_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  logic           res_valid,
	input  tlvd_pkg::res_t res,
	input  logic           out_ready,
	output logic           fire,
	output logic           out_valid,
	output tlvd_pkg::res_t res_s2
);
	import tlvd_pkg::*;

	assign fire = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

>>> sv/command_tlv_deframer_core.sv
// channel   handshake               payload
// input     in_valid / in_ready     rx_byte
// output    out_valid / out_ready   command_code, payload_byte, payload_index,
//                                   has_data, last, overflow
// config    cfg_we                  cfg_wdata (max_payload)
//
// One byte per cycle sustained while out_ready is high; a taken byte goes into the
// input register, is parsed, and its result, if any, is presented from the result register.
// Reset: awaiting a command byte, command 255, max_payload 64, no item held.
// A stalled output holds its item; the input register keeps taking bytes
// until both registers are full.
module command_tlv_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  command_code,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic        has_data,
	output logic        last,
	output logic        overflow
);
	import tlvd_pkg::*;

	logic       fire;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid;
	res_t       res;
	res_t       res_s2;

	tlvd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	tlvd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	tlvd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.fire      (fire),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	assign command_code  = res_s2.command_code;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign has_data      = res_s2.has_data;
	assign last          = res_s2.last;
	assign overflow      = res_s2.overflow;

	a_notice_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_data) |-> (last && !overflow && payload_index == 16'd0))
		else $error("malformed zero-length notice");

endmodule
